// ===== hw/rtl/vrip_pkg.sv =====
// ----------------------------------------------------------------------------
// vrip_pkg
// Shared widths, register codes, coefficient bundle and fixed-point helpers
// for the vertex rotate and isometric projection pipeline.
// ----------------------------------------------------------------------------
package vrip_pkg;

    localparam int ZOOM_W     = 7;
    localparam int MAP_W      = 11;
    localparam int ANG_W      = 8;
    localparam int COL_W      = 10;
    localparam int HGT_W      = 16;
    localparam int SCR_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int SCL_W      = COL_W + ZOOM_W;
    localparam int HZ_W       = HGT_W + ZOOM_W + 1;
    localparam int ABS_W      = HGT_W + ZOOM_W;
    localparam int DIV5_MUL_W = 22;
    localparam int DIV5_SHIFT = 24;
    localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 22'd3355444;
    localparam int DIV5_PROD_W = ABS_W + DIV5_MUL_W;
    localparam int Z_W        = DIV5_PROD_W - DIV5_SHIFT;

    localparam int COEF_W     = 16;
    localparam int COORD_W    = 26;
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int D_W        = COORD_W + 1;
    localparam int PPROD_W    = D_W + COEF_W;
    localparam int SUM_W      = 46;
    localparam int Q_FRAC     = 14;
    localparam int OFF_W      = 20;
    localparam int MAPZ_W     = MAP_W + ZOOM_W;
    localparam int RAW_W      = 32;
    localparam int QIDX_W     = 7;
    localparam int QVAL_W     = 15;
    localparam int QUARTER    = 64;
    localparam int HALF_TURN  = 128;

    localparam logic signed [RAW_W-1:0] COS_OFFSET = 32'sd15652;
    localparam logic signed [RAW_W-1:0] SIN_OFFSET = 32'sd4842;
    localparam logic signed [RAW_W-1:0] RAW_HALF   = RAW_W'(1 << (Q_FRAC - 1));
    localparam logic signed [SUM_W-1:0] SUM_BIAS   = SUM_W'((1 << Q_FRAC) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'((1 << (SCR_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN    = ~SAT_MAX;

    localparam logic [ZOOM_W-1:0] ZOOM_RESET  = 7'd20;
    localparam logic [MAP_W-1:0]  MAP_RESET   = 11'd1;
    localparam logic [ANG_W-1:0]  ANGLE_RESET = 8'd0;
    localparam logic [ANG_W-1:0]  PROJ_RESET  = 8'd21;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZOOM        = 3'd0,
        REG_MAP_COLUMNS = 3'd1,
        REG_MAP_ROWS    = 3'd2,
        REG_ANGLE_X     = 3'd3,
        REG_ANGLE_Y     = 3'd4,
        REG_ANGLE_Z     = 3'd5,
        REG_PROJ_ANGLE  = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic        [ZOOM_W-1:0] zoom;
        logic signed [COEF_W-1:0] cx;
        logic signed [COEF_W-1:0] sx;
        logic signed [COEF_W-1:0] cy;
        logic signed [COEF_W-1:0] sy;
        logic signed [COEF_W-1:0] cz;
        logic signed [COEF_W-1:0] sz;
        logic signed [COEF_W-1:0] cp;
        logic signed [COEF_W-1:0] sp;
        logic signed [OFF_W-1:0]  xoff;
        logic signed [OFF_W-1:0]  yoff;
    } t_coef;

    function automatic logic [QVAL_W-1:0] q_sine(input logic [QIDX_W-1:0] k);
        case (k)
            7'd0:  return 15'd0;     7'd1:  return 15'd402;   7'd2:  return 15'd804;
            7'd3:  return 15'd1205;  7'd4:  return 15'd1606;  7'd5:  return 15'd2006;
            7'd6:  return 15'd2404;  7'd7:  return 15'd2801;  7'd8:  return 15'd3196;
            7'd9:  return 15'd3590;  7'd10: return 15'd3981;  7'd11: return 15'd4370;
            7'd12: return 15'd4756;  7'd13: return 15'd5139;  7'd14: return 15'd5520;
            7'd15: return 15'd5897;  7'd16: return 15'd6270;  7'd17: return 15'd6639;
            7'd18: return 15'd7005;  7'd19: return 15'd7366;  7'd20: return 15'd7723;
            7'd21: return 15'd8076;  7'd22: return 15'd8423;  7'd23: return 15'd8765;
            7'd24: return 15'd9102;  7'd25: return 15'd9434;  7'd26: return 15'd9760;
            7'd27: return 15'd10080; 7'd28: return 15'd10394; 7'd29: return 15'd10702;
            7'd30: return 15'd11003; 7'd31: return 15'd11297; 7'd32: return 15'd11585;
            7'd33: return 15'd11866; 7'd34: return 15'd12140; 7'd35: return 15'd12406;
            7'd36: return 15'd12665; 7'd37: return 15'd12916; 7'd38: return 15'd13160;
            7'd39: return 15'd13395; 7'd40: return 15'd13623; 7'd41: return 15'd13842;
            7'd42: return 15'd14053; 7'd43: return 15'd14256; 7'd44: return 15'd14449;
            7'd45: return 15'd14635; 7'd46: return 15'd14811; 7'd47: return 15'd14978;
            7'd48: return 15'd15137; 7'd49: return 15'd15286; 7'd50: return 15'd15426;
            7'd51: return 15'd15557; 7'd52: return 15'd15679; 7'd53: return 15'd15791;
            7'd54: return 15'd15893; 7'd55: return 15'd15986; 7'd56: return 15'd16069;
            7'd57: return 15'd16143; 7'd58: return 15'd16207; 7'd59: return 15'd16261;
            7'd60: return 15'd16305; 7'd61: return 15'd16340; 7'd62: return 15'd16364;
            7'd63: return 15'd16379; 7'd64: return 15'd16384;
            default: return 15'd0;
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] sine_of(input logic [ANG_W-1:0] code);
        logic [QIDX_W-1:0]        k;
        logic signed [COEF_W-1:0] v;
        k = QIDX_W'(code[ANG_W-3:0]);
        if (code[ANG_W-2]) begin
            k = QIDX_W'(QUARTER) - k;
        end
        v = COEF_W'(q_sine(k));
        return code[ANG_W-1] ? -v : v;
    endfunction

    function automatic logic signed [COEF_W-1:0] cosine_of(input logic [ANG_W-1:0] code);
        return sine_of(code + ANG_W'(QUARTER));
    endfunction

    function automatic logic signed [RAW_W-1:0] round_q14(input logic signed [RAW_W-1:0] v);
        logic signed [RAW_W-1:0] m;
        m = -v;
        if (v < 0) begin
            return -((m + RAW_HALF) >>> Q_FRAC);
        end
        return (v + RAW_HALF) >>> Q_FRAC;
    endfunction

    function automatic logic signed [SUM_W-1:0] trunc_q14(input logic signed [SUM_W-1:0] v);
        if (v < 0) begin
            return (v + SUM_BIAS) >>> Q_FRAC;
        end
        return v >>> Q_FRAC;
    endfunction

    function automatic logic signed [SCR_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[SCR_W-1:0];
        end
        if (v < SAT_MIN) begin
            return SAT_MIN[SCR_W-1:0];
        end
        return v[SCR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/vrip_cfg.sv =====
// ----------------------------------------------------------------------------
// vrip_cfg
// Configuration registers and the coefficient set derived from them:
// rotation sines and cosines, the offset-corrected x rotation and screen offsets.
// ----------------------------------------------------------------------------
module vrip_cfg #(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1080
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [vrip_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vrip_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_cfg_ready,
    output vrip_pkg::t_coef                    o_coef
);
    import vrip_pkg::*;

    logic        [ZOOM_W-1:0] r_zoom;
    logic        [MAP_W-1:0]  r_map_columns;
    logic        [MAP_W-1:0]  r_map_rows;
    logic        [ANG_W-1:0]  r_angle_x;
    logic        [ANG_W-1:0]  r_angle_y;
    logic        [ANG_W-1:0]  r_angle_z;
    logic        [ANG_W-1:0]  r_proj_angle;

    logic signed [RAW_W-1:0]  r_cx_raw;
    logic signed [RAW_W-1:0]  r_sx_raw;
    t_coef                    r_coef;

    logic signed [COEF_W-1:0] w_ca;
    logic signed [COEF_W-1:0] w_sa;
    logic signed [RAW_W-1:0]  n_cx_raw;
    logic signed [RAW_W-1:0]  n_sx_raw;
    logic        [MAPZ_W-1:0] w_col_z;
    logic        [MAPZ_W-1:0] w_row_z;
    logic signed [RAW_W-1:0]  w_cx;
    logic signed [RAW_W-1:0]  w_sx;
    t_coef                    n_coef;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom        <= ZOOM_RESET;
            r_map_columns <= MAP_RESET;
            r_map_rows    <= MAP_RESET;
            r_angle_x     <= ANGLE_RESET;
            r_angle_y     <= ANGLE_RESET;
            r_angle_z     <= ANGLE_RESET;
            r_proj_angle  <= PROJ_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_ZOOM:        r_zoom        <= i_cfg_data[ZOOM_W-1:0];
                REG_MAP_COLUMNS: r_map_columns <= i_cfg_data[MAP_W-1:0];
                REG_MAP_ROWS:    r_map_rows    <= i_cfg_data[MAP_W-1:0];
                REG_ANGLE_X:     r_angle_x     <= i_cfg_data[ANG_W-1:0];
                REG_ANGLE_Y:     r_angle_y     <= i_cfg_data[ANG_W-1:0];
                REG_ANGLE_Z:     r_angle_z     <= i_cfg_data[ANG_W-1:0];
                REG_PROJ_ANGLE:  r_proj_angle  <= i_cfg_data[ANG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_ca     = cosine_of(r_angle_x);
        w_sa     = sine_of(r_angle_x);
        n_cx_raw = RAW_W'(w_ca) * COS_OFFSET + RAW_W'(w_sa) * SIN_OFFSET;
        n_sx_raw = RAW_W'(w_sa) * COS_OFFSET - RAW_W'(w_ca) * SIN_OFFSET;
        w_col_z  = r_map_columns * r_zoom;
        w_row_z  = r_map_rows * r_zoom;
        w_cx     = round_q14(r_cx_raw);
        w_sx     = round_q14(r_sx_raw);

        n_coef.zoom = r_zoom;
        n_coef.cx   = w_cx[COEF_W-1:0];
        n_coef.sx   = w_sx[COEF_W-1:0];
        n_coef.cy   = cosine_of(r_angle_y);
        n_coef.sy   = sine_of(r_angle_y);
        n_coef.cz   = cosine_of(r_angle_z + ANG_W'(HALF_TURN));
        n_coef.sz   = sine_of(r_angle_z + ANG_W'(HALF_TURN));
        n_coef.cp   = cosine_of(r_proj_angle);
        n_coef.sp   = -sine_of(r_proj_angle);
        n_coef.xoff = OFF_W'(SCREEN_WIDTH) - OFF_W'(w_col_z);
        n_coef.yoff = OFF_W'(SCREEN_HEIGHT / 2) - OFF_W'(w_row_z >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_cx_raw <= n_cx_raw;
        r_sx_raw <= n_sx_raw;
        r_coef   <= n_coef;
    end

    always_comb begin
        o_coef      = r_coef;
        o_coef.zoom = r_zoom;
    end

endmodule

// ===== hw/rtl/vrip_scale.sv =====
// ----------------------------------------------------------------------------
// vrip_scale
// Three-stage front end: scale column, row and height by zoom, then divide
// the scaled height by five toward zero through a reciprocal multiply.
// ----------------------------------------------------------------------------
module vrip_scale (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic        [vrip_pkg::COL_W-1:0]     i_grid_col,
    input  logic        [vrip_pkg::COL_W-1:0]     i_grid_row,
    input  logic signed [vrip_pkg::HGT_W-1:0]     i_height,
    input  logic        [vrip_pkg::ZOOM_W-1:0]    i_zoom,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [vrip_pkg::COORD_W-1:0]   o_x,
    output logic signed [vrip_pkg::COORD_W-1:0]   o_y,
    output logic signed [vrip_pkg::COORD_W-1:0]   o_z
);
    import vrip_pkg::*;

    logic [2:0]                 r_v;
    logic [2:0]                 w_en;

    logic        [SCL_W-1:0]       r1_x;
    logic        [SCL_W-1:0]       r1_y;
    logic signed [HZ_W-1:0]        r1_hz;
    logic        [SCL_W-1:0]       r2_x;
    logic        [SCL_W-1:0]       r2_y;
    logic                          r2_neg;
    logic        [DIV5_PROD_W-1:0] r2_prod;
    logic signed [COORD_W-1:0]     r3_x;
    logic signed [COORD_W-1:0]     r3_y;
    logic signed [COORD_W-1:0]     r3_z;

    logic        [SCL_W-1:0]       n1_x;
    logic        [SCL_W-1:0]       n1_y;
    logic signed [HZ_W-1:0]        n1_hz;
    logic signed [HZ_W-1:0]        w_hz_mag;
    logic        [ABS_W-1:0]       w_abs;
    logic        [DIV5_PROD_W-1:0] n2_prod;
    logic        [Z_W-1:0]         w_q;
    logic signed [COORD_W-1:0]     n3_z;

    assign w_en[2] = !r_v[2] || !i_stall;
    assign w_en[1] = !r_v[1] || w_en[2];
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_stall = !w_en[0];

    always_comb begin
        n1_x     = i_grid_col * i_zoom;
        n1_y     = i_grid_row * i_zoom;
        n1_hz    = i_height * $signed({1'b0, i_zoom});
        w_hz_mag = r1_hz[HZ_W-1] ? -r1_hz : r1_hz;
        w_abs    = w_hz_mag[ABS_W-1:0];
        n2_prod  = w_abs * DIV5_MUL;
        w_q      = r2_prod[DIV5_PROD_W-1:DIV5_SHIFT];
        n3_z     = r2_neg ? -COORD_W'(w_q) : COORD_W'(w_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_en[1]) begin
                r_v[1] <= r_v[0];
            end
            if (w_en[2]) begin
                r_v[2] <= r_v[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_x  <= n1_x;
            r1_y  <= n1_y;
            r1_hz <= n1_hz;
        end
        if (w_en[1]) begin
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_neg  <= r1_hz[HZ_W-1];
            r2_prod <= n2_prod;
        end
        if (w_en[2]) begin
            r3_x <= COORD_W'(r2_x);
            r3_y <= COORD_W'(r2_y);
            r3_z <= n3_z;
        end
    end

    assign o_valid = r_v[2];
    assign o_x     = r3_x;
    assign o_y     = r3_y;
    assign o_z     = r3_z;

endmodule

// ===== hw/rtl/vrip_rot.sv =====
// ----------------------------------------------------------------------------
// vrip_rot
// Two-stage plane rotation: four products, then the two Q1.14 sums truncated
// toward zero. The third coordinate rides along unchanged.
// ----------------------------------------------------------------------------
module vrip_rot (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [vrip_pkg::COORD_W-1:0]   i_a,
    input  logic signed [vrip_pkg::COORD_W-1:0]   i_b,
    input  logic signed [vrip_pkg::COORD_W-1:0]   i_pass,
    input  logic signed [vrip_pkg::COEF_W-1:0]    i_c,
    input  logic signed [vrip_pkg::COEF_W-1:0]    i_s,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [vrip_pkg::COORD_W-1:0]   o_p,
    output logic signed [vrip_pkg::COORD_W-1:0]   o_q,
    output logic signed [vrip_pkg::COORD_W-1:0]   o_pass
);
    import vrip_pkg::*;

    logic [1:0]                r_v;
    logic [1:0]                w_en;

    logic signed [PROD_W-1:0]  r1_ac;
    logic signed [PROD_W-1:0]  r1_bs;
    logic signed [PROD_W-1:0]  r1_as;
    logic signed [PROD_W-1:0]  r1_bc;
    logic signed [COORD_W-1:0] r1_pass;
    logic signed [COORD_W-1:0] r2_p;
    logic signed [COORD_W-1:0] r2_q;
    logic signed [COORD_W-1:0] r2_pass;

    logic signed [PROD_W-1:0]  n1_ac;
    logic signed [PROD_W-1:0]  n1_bs;
    logic signed [PROD_W-1:0]  n1_as;
    logic signed [PROD_W-1:0]  n1_bc;
    logic signed [SUM_W-1:0]   w_p;
    logic signed [SUM_W-1:0]   w_q;

    assign w_en[1] = !r_v[1] || !i_stall;
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_stall = !w_en[0];

    always_comb begin
        n1_ac = i_a * i_c;
        n1_bs = i_b * i_s;
        n1_as = i_a * i_s;
        n1_bc = i_b * i_c;
        w_p   = trunc_q14(SUM_W'(r1_ac) - SUM_W'(r1_bs));
        w_q   = trunc_q14(SUM_W'(r1_as) + SUM_W'(r1_bc));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_en[1]) begin
                r_v[1] <= r_v[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_ac   <= n1_ac;
            r1_bs   <= n1_bs;
            r1_as   <= n1_as;
            r1_bc   <= n1_bc;
            r1_pass <= i_pass;
        end
        if (w_en[1]) begin
            r2_p    <= w_p[COORD_W-1:0];
            r2_q    <= w_q[COORD_W-1:0];
            r2_pass <= r1_pass;
        end
    end

    assign o_valid = r_v[1];
    assign o_p     = r2_p;
    assign o_q     = r2_q;
    assign o_pass  = r2_pass;

endmodule

// ===== hw/rtl/vrip_proj.sv =====
// ----------------------------------------------------------------------------
// vrip_proj
// Three-stage isometric projection: difference and sum, products with the
// projection cosine and negated sine, then offset add, truncate and saturate.
// ----------------------------------------------------------------------------
module vrip_proj (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [vrip_pkg::COORD_W-1:0]   i_x,
    input  logic signed [vrip_pkg::COORD_W-1:0]   i_y,
    input  logic signed [vrip_pkg::COORD_W-1:0]   i_z,
    input  vrip_pkg::t_coef                       i_coef,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [vrip_pkg::SCR_W-1:0]     o_screen_x,
    output logic signed [vrip_pkg::SCR_W-1:0]     o_screen_y
);
    import vrip_pkg::*;

    logic [2:0]                 r_v;
    logic [2:0]                 w_en;

    logic signed [D_W-1:0]      r1_d;
    logic signed [D_W-1:0]      r1_e;
    logic signed [COORD_W-1:0]  r1_z;
    logic signed [PPROD_W-1:0]  r2_pd;
    logic signed [PPROD_W-1:0]  r2_pe;
    logic signed [COORD_W-1:0]  r2_z;
    logic signed [SCR_W-1:0]    r3_sx;
    logic signed [SCR_W-1:0]    r3_sy;

    logic signed [D_W-1:0]      n1_d;
    logic signed [D_W-1:0]      n1_e;
    logic signed [PPROD_W-1:0]  n2_pd;
    logic signed [PPROD_W-1:0]  n2_pe;
    logic signed [SUM_W-1:0]    w_num_x;
    logic signed [SUM_W-1:0]    w_num_y;

    assign w_en[2] = !r_v[2] || !i_stall;
    assign w_en[1] = !r_v[1] || w_en[2];
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_stall = !w_en[0];

    always_comb begin
        n1_d    = D_W'(i_x) - D_W'(i_y);
        n1_e    = D_W'(i_x) + D_W'(i_y);
        n2_pd   = r1_d * i_coef.cp;
        n2_pe   = r1_e * i_coef.sp;
        w_num_x = SUM_W'(r2_pd) + (SUM_W'(i_coef.xoff) <<< Q_FRAC);
        w_num_y = SUM_W'(r2_pe) + ((SUM_W'(i_coef.yoff) - SUM_W'(r2_z)) <<< Q_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_en[1]) begin
                r_v[1] <= r_v[0];
            end
            if (w_en[2]) begin
                r_v[2] <= r_v[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_d <= n1_d;
            r1_e <= n1_e;
            r1_z <= i_z;
        end
        if (w_en[1]) begin
            r2_pd <= n2_pd;
            r2_pe <= n2_pe;
            r2_z  <= r1_z;
        end
        if (w_en[2]) begin
            r3_sx <= saturate(trunc_q14(w_num_x));
            r3_sy <= saturate(trunc_q14(w_num_y));
        end
    end

    assign o_valid    = r_v[2];
    assign o_screen_x = r3_sx;
    assign o_screen_y = r3_sy;

endmodule

// ===== hw/rtl/vertex_rotate_isometric_project.sv =====
// ----------------------------------------------------------------------------
// Throughput: one vertex per clock while the output is not stalled; twelve
// register stages, each at most one multiplier deep, with per-stage valid
// bits that close bubbles under stall. Reset clears all valid bits and loads
// the register defaults; derived coefficients are registered from the
// configuration registers, x rotation through an extra raw register.
// ----------------------------------------------------------------------------
// vertex_rotate_isometric_project
// Scales a map vertex by zoom, rotates it about x, y and z, and projects it
// isometrically to saturated 24-bit screen coordinates.
// ----------------------------------------------------------------------------
module vertex_rotate_isometric_project #(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1080
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic        [vrip_pkg::COL_W-1:0]     i_grid_col,
    input  logic        [vrip_pkg::COL_W-1:0]     i_grid_row,
    input  logic signed [vrip_pkg::HGT_W-1:0]     i_height,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [vrip_pkg::SCR_W-1:0]     o_screen_x,
    output logic signed [vrip_pkg::SCR_W-1:0]     o_screen_y,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [vrip_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [vrip_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vrip_pkg::*;

    t_coef                     w_coef;

    logic                      w_s_valid;
    logic                      w_s_stall;
    logic signed [COORD_W-1:0] w_s_x;
    logic signed [COORD_W-1:0] w_s_y;
    logic signed [COORD_W-1:0] w_s_z;

    logic                      w_rx_valid;
    logic                      w_rx_stall;
    logic signed [COORD_W-1:0] w_rx_y;
    logic signed [COORD_W-1:0] w_rx_z;
    logic signed [COORD_W-1:0] w_rx_x;

    logic                      w_ry_valid;
    logic                      w_ry_stall;
    logic signed [COORD_W-1:0] w_ry_x;
    logic signed [COORD_W-1:0] w_ry_z;
    logic signed [COORD_W-1:0] w_ry_y;

    logic                      w_rz_valid;
    logic                      w_rz_stall;
    logic signed [COORD_W-1:0] w_rz_y;
    logic signed [COORD_W-1:0] w_rz_x;
    logic signed [COORD_W-1:0] w_rz_z;

    logic                      w_p_stall;

    vrip_cfg #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_coef      (w_coef)
    );

    vrip_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_grid_col (i_grid_col),
        .i_grid_row (i_grid_row),
        .i_height   (i_height),
        .i_zoom     (w_coef.zoom),
        .o_valid    (w_s_valid),
        .i_stall    (w_s_stall),
        .o_x        (w_s_x),
        .o_y        (w_s_y),
        .o_z        (w_s_z)
    );

    vrip_rot u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s_valid),
        .o_stall (w_s_stall),
        .i_a     (w_s_y),
        .i_b     (w_s_z),
        .i_pass  (w_s_x),
        .i_c     (w_coef.cx),
        .i_s     (w_coef.sx),
        .o_valid (w_rx_valid),
        .i_stall (w_rx_stall),
        .o_p     (w_rx_y),
        .o_q     (w_rx_z),
        .o_pass  (w_rx_x)
    );

    vrip_rot u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rx_valid),
        .o_stall (w_rx_stall),
        .i_a     (w_rx_x),
        .i_b     (w_rx_z),
        .i_pass  (w_rx_y),
        .i_c     (w_coef.cy),
        .i_s     (w_coef.sy),
        .o_valid (w_ry_valid),
        .i_stall (w_ry_stall),
        .o_p     (w_ry_x),
        .o_q     (w_ry_z),
        .o_pass  (w_ry_y)
    );

    vrip_rot u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ry_valid),
        .o_stall (w_ry_stall),
        .i_a     (w_ry_x),
        .i_b     (w_ry_y),
        .i_pass  (w_ry_z),
        .i_c     (w_coef.cz),
        .i_s     (w_coef.sz),
        .o_valid (w_rz_valid),
        .i_stall (w_rz_stall),
        .o_p     (w_rz_y),
        .o_q     (w_rz_x),
        .o_pass  (w_rz_z)
    );

    vrip_proj u_proj (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_rz_valid),
        .o_stall    (w_p_stall),
        .i_x        (w_rz_x),
        .i_y        (w_rz_y),
        .i_z        (w_rz_z),
        .i_coef     (w_coef),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y)
    );

    assign w_rz_stall = w_p_stall;

endmodule

// ===== tb/vertex_rotate_isometric_project_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_isometric_project_tb
// Streams map vertices through the rotate and isometric projection pipeline
// under many register settings. A behavioral projection model predicts every
// screen point, and each output transaction is compared field by field, in
// order, against the oldest prediction. Both handshakes idle and stall at
// random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module vertex_rotate_isometric_project_tb;
    import vrip_pkg::*;

    localparam int     SCR_WIDTH   = 1920;
    localparam int     SCR_HEIGHT  = 1080;
    localparam int     PIPE_DEPTH  = 12;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     RAND_PHASES = 10;
    localparam int     PHASE_ITEMS = 70;
    localparam longint ONE_Q14     = 16384;
    localparam longint ROT_COS     = 15652;
    localparam longint ROT_SIN     = 4842;
    localparam longint SCREEN_MAX  = 8388607;
    localparam longint SCREEN_MIN  = -8388608;

    typedef struct packed {
        logic signed [SCR_W-1:0] sx;
        logic signed [SCR_W-1:0] sy;
    } t_screen_pt;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic                         o_stall;
    logic        [COL_W-1:0]      i_grid_col  = '0;
    logic        [COL_W-1:0]      i_grid_row  = '0;
    logic signed [HGT_W-1:0]      i_height    = '0;
    logic                         o_valid;
    logic                         i_stall     = 1'b0;
    logic signed [SCR_W-1:0]      o_screen_x;
    logic signed [SCR_W-1:0]      o_screen_y;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic        [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic        [CFG_DATA_W-1:0] i_cfg_data  = '0;

    longint quarter_wave [65] = '{
        0, 402, 804, 1205, 1606, 2006, 2404, 2801,
        3196, 3590, 3981, 4370, 4756, 5139, 5520, 5897,
        6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765,
        9102, 9434, 9760, 10080, 10394, 10702, 11003, 11297,
        11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
        13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
        15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
        16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
        16384
    };

    logic [ZOOM_W-1:0] cfg_zoom     = ZOOM_RESET;
    logic [MAP_W-1:0]  cfg_map_cols = MAP_RESET;
    logic [MAP_W-1:0]  cfg_map_rows = MAP_RESET;
    logic [ANG_W-1:0]  cfg_angle_x  = ANGLE_RESET;
    logic [ANG_W-1:0]  cfg_angle_y  = ANGLE_RESET;
    logic [ANG_W-1:0]  cfg_angle_z  = ANGLE_RESET;
    logic [ANG_W-1:0]  cfg_proj     = PROJ_RESET;

    t_screen_pt pending_points [$];
    int         cycle_count    = 0;
    int         mismatch_count = 0;
    int         vertices_sent  = 0;
    int         points_checked = 0;
    int         reg_writes     = 0;
    bit         tx_quiet       = 1'b0;
    bit         rx_quiet       = 1'b0;

    vertex_rotate_isometric_project #(
        .SCREEN_WIDTH (SCR_WIDTH),
        .SCREEN_HEIGHT(SCR_HEIGHT)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_grid_col (i_grid_col),
        .i_grid_row (i_grid_row),
        .i_height   (i_height),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d points outstanding", $time, pending_points.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint sin_code(input logic [ANG_W-1:0] a);
        longint v;
        int     k;
        k = int'(a[5:0]);
        v = a[6] ? quarter_wave[64 - k] : quarter_wave[k];
        return a[7] ? -v : v;
    endfunction

    function automatic longint cos_code(input logic [ANG_W-1:0] a);
        return sin_code(a + 8'd64);
    endfunction

    function automatic longint round_half_away(input longint v);
        if (v < 0) begin
            return -((-v + ONE_Q14 / 2) / ONE_Q14);
        end
        return (v + ONE_Q14 / 2) / ONE_Q14;
    endfunction

    function automatic logic signed [SCR_W-1:0] clamp_screen(input longint v);
        if (v > SCREEN_MAX) begin
            return SCR_W'(SCREEN_MAX);
        end
        if (v < SCREEN_MIN) begin
            return SCR_W'(SCREEN_MIN);
        end
        return SCR_W'(v);
    endfunction

    function automatic t_screen_pt project_vertex(input logic [COL_W-1:0] col,
                                                  input logic [COL_W-1:0] row,
                                                  input logic signed [HGT_W-1:0] h);
        longint     px, py, pz, zm, ca, sa, c, s, t1, t2, xo, yo, sx, sy;
        t_screen_pt pt;
        zm = longint'(cfg_zoom);
        px = longint'(col) * zm;
        py = longint'(row) * zm;
        pz = (longint'(h) * zm) / 5;

        ca = cos_code(cfg_angle_x);
        sa = sin_code(cfg_angle_x);
        c  = round_half_away(ca * ROT_COS + sa * ROT_SIN);
        s  = round_half_away(sa * ROT_COS - ca * ROT_SIN);
        t1 = (py * c - pz * s) / ONE_Q14;
        t2 = (py * s + pz * c) / ONE_Q14;
        py = t1;
        pz = t2;

        c  = cos_code(cfg_angle_y);
        s  = sin_code(cfg_angle_y);
        t1 = (px * c - pz * s) / ONE_Q14;
        t2 = (px * s + pz * c) / ONE_Q14;
        px = t1;
        pz = t2;

        c  = cos_code(cfg_angle_z + 8'd128);
        s  = sin_code(cfg_angle_z + 8'd128);
        t1 = (px * c - py * s) / ONE_Q14;
        t2 = (px * s + py * c) / ONE_Q14;
        py = t1;
        px = t2;

        xo = longint'(SCR_WIDTH) - longint'(cfg_map_cols) * zm;
        yo = longint'(SCR_HEIGHT / 2) - (longint'(cfg_map_rows) * zm) / 2;
        c  = cos_code(cfg_proj);
        s  = -sin_code(cfg_proj);
        sx = ((px - py) * c + xo * ONE_Q14) / ONE_Q14;
        sy = ((px + py) * s - pz * ONE_Q14 + yo * ONE_Q14) / ONE_Q14;
        pt.sx = clamp_screen(sx);
        pt.sy = clamp_screen(sy);
        return pt;
    endfunction

    function automatic int draw_wait(input bit quiet);
        if (quiet || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Check each output transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_screen_pt want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected point, expected none, got x=%0d y=%0d",
                         $time, o_screen_x, o_screen_y);
                mismatch_count++;
            end else begin
                want = pending_points.pop_front();
                points_checked++;
                if (o_screen_x !== want.sx) begin
                    $display("%0t: screen_x mismatch, expected %0d, got %0d",
                             $time, want.sx, o_screen_x);
                    mismatch_count++;
                end
                if (o_screen_y !== want.sy) begin
                    $display("%0t: screen_y mismatch, expected %0d, got %0d",
                             $time, want.sy, o_screen_y);
                    mismatch_count++;
                end
            end
        end
    end

    // Output side backpressure.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0) begin
                rx_quiet = !rx_quiet;
            end
            n = draw_wait(rx_quiet);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && !i_stall));
        end
    end

    task automatic send_vertex(input logic [COL_W-1:0] col,
                               input logic [COL_W-1:0] row,
                               input logic signed [HGT_W-1:0] h);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            tx_quiet = !tx_quiet;
        end
        gap = draw_wait(tx_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_grid_col <= col;
        i_grid_row <= row;
        i_height   <= h;
        do @(posedge i_clk); while (o_stall);
        pending_points.push_back(project_vertex(col, row, h));
        vertices_sent++;
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_points.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ZOOM:        cfg_zoom     = data[ZOOM_W-1:0];
            REG_MAP_COLUMNS: cfg_map_cols = data[MAP_W-1:0];
            REG_MAP_ROWS:    cfg_map_rows = data[MAP_W-1:0];
            REG_ANGLE_X:     cfg_angle_x  = data[ANG_W-1:0];
            REG_ANGLE_Y:     cfg_angle_y  = data[ANG_W-1:0];
            REG_ANGLE_Z:     cfg_angle_z  = data[ANG_W-1:0];
            REG_PROJ_ANGLE:  cfg_proj     = data[ANG_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input int zoom, input int cols, input int rows,
                                 input int ax, input int ay, input int az, input int proj);
        drain_pipeline();
        write_reg(REG_ZOOM, CFG_DATA_W'(zoom));
        write_reg(REG_MAP_COLUMNS, CFG_DATA_W'(cols));
        write_reg(REG_MAP_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_ANGLE_X, CFG_DATA_W'(ax));
        write_reg(REG_ANGLE_Y, CFG_DATA_W'(ay));
        write_reg(REG_ANGLE_Z, CFG_DATA_W'(az));
        write_reg(REG_PROJ_ANGLE, CFG_DATA_W'(proj));
    endtask

    task automatic test_reset_settings();
        send_vertex(10'd0, 10'd0, 16'sd0);
        send_vertex(10'd1023, 10'd1023, 16'sd32767);
        send_vertex(10'd1023, 10'd0, -16'sd32768);
        send_vertex(10'd0, 10'd1023, -16'sd1);
        send_vertex(10'd341, 10'd682, 16'sd21845);
    endtask

    task automatic test_zoom_and_map_extremes();
        // zero zoom collapses every vertex onto the offsets
        load_settings(0, 7, 9, 37, 200, 99, 21);
        send_vertex(10'd1023, 10'd1023, -16'sd32768);
        send_vertex(10'd512, 10'd3, 16'sd32767);
        // zoom and map sizes beyond their nominal ranges
        load_settings(127, 2047, 2047, 0, 0, 0, 21);
        send_vertex(10'd1023, 10'd1023, 16'sd32767);
        send_vertex(10'd0, 10'd1023, -16'sd32768);
        load_settings(127, 0, 0, 255, 255, 255, 255);
        send_vertex(10'd1023, 10'd0, -16'sd32768);
        load_settings(64, 1024, 1024, 128, 64, 192, 0);
        send_vertex(10'd1023, 10'd1023, 16'sd32767);
        send_vertex(10'd1, 10'd2, -16'sd5);
    endtask

    task automatic test_angle_wrap();
        load_settings(1, 1, 1, 255, 128, 128, 64);
        send_vertex(10'd1023, 10'd512, 16'sd100);
        send_vertex(10'd0, 10'd1, -16'sd32768);
        load_settings(33, 512, 300, 64, 192, 0, 128);
        send_vertex(10'd700, 10'd200, 16'sd12345);
        send_vertex(10'd5, 10'd1000, -16'sd4);
        load_settings(17, 100, 1000, 192, 1, 127, 192);
        send_vertex(10'd999, 10'd333, -16'sd7777);
        send_vertex(10'd1023, 10'd1023, 16'sd32767);
        load_settings(20, 1, 1, 0, 0, 0, 21);
    endtask

    function automatic int pick_value(input int lo, input int hi, input int wide_hi);
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            2:       return $urandom_range(0, wide_hi);
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic test_random_stream();
        logic signed [HGT_W-1:0] h;
        logic        [COL_W-1:0] col, row;
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                load_settings(1, 1, 1, 0, 0, 0, 0);
            end else if (p == 1) begin
                load_settings(64, 1024, 1024, 255, 255, 255, 255);
            end else begin
                load_settings(pick_value(1, 64, 127), pick_value(1, 1024, 2047),
                              pick_value(1, 1024, 2047), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255));
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                col = COL_W'($urandom_range(0, 1023));
                row = COL_W'($urandom_range(0, 1023));
                case ($urandom_range(0, 3))
                    0:       h = HGT_W'($urandom_range(0, 400)) - 16'sd200;
                    1:       h = ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768;
                    default: h = HGT_W'($urandom());
                endcase
                send_vertex(col, row, h);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_zoom_and_map_extremes();
        test_angle_wrap();
        test_random_stream();

        drain_pipeline();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        $display("Projected %0d vertices through %0d register writes; %0d points checked.",
                 vertices_sent, reg_writes, points_checked);
        $display("Covered zoom and map size extremes, angle wrap, and random streams.");
        if (mismatch_count == 0 && pending_points.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d points never arrived",
                     mismatch_count, pending_points.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
